>>> design/tesc_pkg.sv
// ----------------------------------------------------------------------------
// tesc_pkg
// Shared types and character codes for the template end-tag scanner.
// ----------------------------------------------------------------------------
package tesc_pkg;

	localparam int unsigned TAG_OFFSET_W = 32;

	// Position inside a candidate closing tag
	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_BRACKET      = 4'd1,
		PH_AFTER_PCT    = 4'd2,
		PH_SPACES       = 4'd3,
		PH_E            = 4'd4,
		PH_N            = 4'd5,
		PH_D            = 4'd6,
		PH_ENDING       = 4'd7,
		PH_CHOMP        = 4'd8,
		PH_PCT_END      = 4'd9,
		PH_COMMENT      = 4'd10,
		PH_COMMENT_PCT  = 4'd11,
		PH_SEMI         = 4'd12,
		PH_SEMI_BRACKET = 4'd13,
		PH_SEMI_PCT     = 4'd14
	} phase_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_FOUND   = 2'd1,
		ST_ENDED   = 2'd2
	} status_t;

	// Decision for one byte
	typedef struct packed {
		phase_t next;
		logic   close;     // tag completes on this byte
		logic   cand_here; // candidate starts at this byte
		logic   cand_prev; // candidate starts at the byte before
	} judge_t;

	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_UPPER_N = 8'h4E;
	localparam logic [7:0] CH_UPPER_D = 8'h44;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

endpackage

>>> design/tesc_judge.sv
// ----------------------------------------------------------------------------
// tesc_judge
// Next-phase decision of the closing-tag matcher for one byte.
// ----------------------------------------------------------------------------
module tesc_judge (
	input  tesc_pkg::phase_t phase,
	input  logic [7:0]       text_byte,
	output tesc_pkg::judge_t verdict
);
	import tesc_pkg::*;

	logic   is_chomp;
	logic   is_blank;
	logic   is_word;
	logic   resolved;
	phase_t eff;

	// Classify the byte
	assign is_chomp = (text_byte == CH_MINUS) || (text_byte == CH_PLUS) ||
	                  (text_byte == CH_EQUAL) || (text_byte == CH_TILDE);
	assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
	                  (text_byte == CH_CR) || (text_byte == CH_LF);
	assign is_word  = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
	                  (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
	                  (text_byte >= 8'h30 && text_byte <= 8'h39) ||
	                  (text_byte == 8'h5F);

	always_comb begin
		verdict  = '{next: PH_IDLE, close: 1'b0, cand_here: 1'b0, cand_prev: 1'b0};
		resolved = 1'b0;
		eff      = phase;

		// Phases that may hand the same byte on to another phase
		unique case (phase)
			PH_D: begin
				eff = is_word ? PH_IDLE : PH_ENDING;
			end
			PH_COMMENT_PCT: begin
				if (text_byte == CH_RBRACK) begin
					verdict.close = 1'b1;
					resolved      = 1'b1;
				end else begin
					eff = PH_COMMENT;
				end
			end
			PH_SEMI_BRACKET: begin
				if (text_byte == CH_PCT) begin
					verdict.next      = PH_AFTER_PCT;
					verdict.cand_prev = 1'b1;
					resolved          = 1'b1;
				end else begin
					eff = PH_SEMI;
				end
			end
			PH_SEMI_PCT: begin
				if (text_byte == CH_RBRACK) begin
					verdict.close = 1'b1;
					resolved      = 1'b1;
				end else begin
					eff = PH_SEMI;
				end
			end
			default: begin
				eff = phase;
			end
		endcase

		// Main step; a failed candidate falls back to the idle judgment
		if (!resolved) begin
			unique case (eff)
				PH_BRACKET: begin
					if (text_byte == CH_PCT) verdict.next = PH_AFTER_PCT;
					else resolved = 1'b1;
				end
				PH_AFTER_PCT: begin
					if (is_chomp || is_blank) verdict.next = PH_SPACES;
					else if (text_byte == CH_UPPER_E) verdict.next = PH_E;
					else resolved = 1'b1;
				end
				PH_SPACES: begin
					if (is_blank) verdict.next = PH_SPACES;
					else if (text_byte == CH_UPPER_E) verdict.next = PH_E;
					else resolved = 1'b1;
				end
				PH_E: begin
					if (text_byte == CH_UPPER_N) verdict.next = PH_N;
					else resolved = 1'b1;
				end
				PH_N: begin
					if (text_byte == CH_UPPER_D) verdict.next = PH_D;
					else resolved = 1'b1;
				end
				PH_ENDING: begin
					if (is_blank) verdict.next = PH_ENDING;
					else if (text_byte == CH_SEMI) verdict.next = PH_SEMI;
					else if (text_byte == CH_HASH) verdict.next = PH_COMMENT;
					else if (is_chomp) verdict.next = PH_CHOMP;
					else if (text_byte == CH_PCT) verdict.next = PH_PCT_END;
					else resolved = 1'b1;
				end
				PH_CHOMP: begin
					if (text_byte == CH_PCT) verdict.next = PH_PCT_END;
					else resolved = 1'b1;
				end
				PH_PCT_END: begin
					if (text_byte == CH_RBRACK) verdict.close = 1'b1;
					else resolved = 1'b1;
				end
				PH_COMMENT: begin
					if (text_byte == CH_LF) verdict.next = PH_ENDING;
					else if (text_byte == CH_PCT) verdict.next = PH_COMMENT_PCT;
					else verdict.next = PH_COMMENT;
				end
				PH_SEMI: begin
					if (text_byte == CH_LBRACK) verdict.next = PH_SEMI_BRACKET;
					else if (text_byte == CH_PCT) verdict.next = PH_SEMI_PCT;
					else verdict.next = PH_SEMI;
				end
				default: begin
					resolved = 1'b1;
				end
			endcase

			// Idle judgment: an opening bracket starts a candidate
			if (resolved) begin
				if (text_byte == CH_LBRACK) begin
					verdict.next      = PH_BRACKET;
					verdict.cand_here = 1'b1;
				end else begin
					verdict.next = PH_IDLE;
				end
			end
		end
	end

endmodule

>>> design/template_end_tag_scanner.sv
// ----------------------------------------------------------------------------
// template_end_tag_scanner
// Finds the first well-formed closing END tag in a stream of body bytes.
// ----------------------------------------------------------------------------
// Path: an accepted item passes through the input register and then the result
//   register, which loads once it is empty or its result is taken; a stalled
//   result stream holds the item in the input register.
// Throughput: one item per cycle while the result stream is not stalled; the
//   phase update lies between the input register and the result register.
// Reset: arst_n clears the phase to idle, the offset, candidate start and
//   closed flag to zero, and empties both registers.
module template_end_tag_scanner #(
	parameter int unsigned OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tlast,  // last_byte
	input  logic        s_axis_tuser,  // [0] start_of_body
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] tag_offset
	output logic [1:0]  m_axis_tuser   // [1:0] scan_status
);
	import tesc_pkg::*;

	localparam int unsigned EXT_W = OFFSET_WIDTH + TAG_OFFSET_W;

	// Input register
	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic                     start_s1;

	// Result register
	logic                     valid_s2;
	logic [TAG_OFFSET_W-1:0]  tag_s2;
	status_t                  status_s2;

	// Scan state
	phase_t                   phase_q;
	logic [OFFSET_WIDTH-1:0]  offset_q;
	logic [OFFSET_WIDTH-1:0]  cand_q;
	logic                     closed_q;

	logic                     advance;
	phase_t                   phase_eff;
	logic [OFFSET_WIDTH-1:0]  pos;
	logic                     closed_eff;
	judge_t                   verdict;
	logic [EXT_W-1:0]         cand_ext;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Apply start of body before judging the byte
	assign phase_eff  = start_s1 ? PH_IDLE : phase_q;
	assign pos        = start_s1 ? '0 : offset_q;
	assign closed_eff = start_s1 ? 1'b0 : closed_q;
	assign cand_ext   = EXT_W'(cand_q);

	tesc_judge u_judge (
		.phase     (phase_eff),
		.text_byte (byte_s1),
		.verdict   (verdict)
	);

	// Capture input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			start_s1 <= s_axis_tuser;
		end
	end

	// Advance scan state and produce result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			cand_q   <= '0;
			closed_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				offset_q <= pos + OFFSET_WIDTH'(1);
				if (closed_eff) begin
					// hold the scan after a close
					phase_q  <= phase_eff;
					closed_q <= 1'b1;
				end else if (verdict.close) begin
					closed_q <= 1'b1;
					phase_q  <= PH_IDLE;
				end else begin
					closed_q <= 1'b0;
					phase_q  <= last_s1 ? PH_IDLE : verdict.next;
					if (verdict.cand_here) cand_q <= pos;
					else if (verdict.cand_prev) cand_q <= pos - OFFSET_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (!closed_eff && verdict.close) begin
				status_s2 <= ST_FOUND;
				tag_s2    <= cand_ext[TAG_OFFSET_W-1:0];
			end else begin
				status_s2 <= (!closed_eff && last_s1) ? ST_ENDED : ST_PENDING;
				tag_s2    <= '0;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = tag_s2;
	assign m_axis_tuser  = status_s2;

endmodule

>>> design/tesc_checker.sv
// ----------------------------------------------------------------------------
// tesc_checker
// Port-level checks on the end-tag scanner's result stream.
// ----------------------------------------------------------------------------
module tesc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import tesc_pkg::*;

	// Status code is always one of the defined results
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_PENDING || m_axis_tuser == ST_FOUND ||
		                   m_axis_tuser == ST_ENDED))
		else $error("scan status out of range");

	// Offset is zero unless a tag was found
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == 32'd0))
		else $error("nonzero offset without a found tag");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind template_end_tag_scanner tesc_checker u_tesc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
